// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the bitmap allocator. Clocked on clk, disabled while
// rst_n is low. Empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property check: lbl names the assertion, prop is any implication.
`define BFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define BFA_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define BFA_ASSERT(lbl, prop, msg)
`define BFA_NEVER(lbl, expr, msg)

`endif

`endif

// File: rtl/bfa_pkg.sv
// ---------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the bitmap first-free allocator.
// ---------------------------------------------------------------------------
package bfa_pkg;

  // Fixed field widths
  localparam int ACT_W   = 2;
  localparam int WIDX_W  = 8;
  localparam int WDATA_W = 32;
  localparam int NUM_W   = 14;   // entry numbers, counts and the limit
  localparam int IN_W    = 56;   // packed request, whole bytes
  localparam int OUT_W   = 32;   // packed result, whole bytes
  localparam int OUT_PAD = OUT_W - (2 * NUM_W + 1);

  localparam logic [NUM_W-1:0] LIMIT_RESET = 14'd8192;

  typedef logic [ACT_W-1:0] action_t;

  // Request action codes
  localparam action_t ACT_LOAD_WORD  = 2'd0;
  localparam action_t ACT_ALLOC      = 2'd1;
  localparam action_t ACT_LOAD_COUNT = 2'd2;

  // Controller -> datapath
  typedef struct packed {
    logic accept;   // request taken this cycle
    logic scan;     // scan in progress
    logic take;     // claim the bit found in the checked word
    logic fail;     // scan ran past the limit
  } bfa_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic hit;        // checked word has a free entry below the limit
    logic exhausted;  // nothing left to read or check
  } bfa_sts_t;

endpackage

// File: rtl/bfa_ctrl.sv
// ---------------------------------------------------------------------------
// bfa_ctrl
// Sequencer: takes a request, runs the bitmap scan, hands the result over.
// ---------------------------------------------------------------------------
module bfa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  bfa_pkg::action_t   in_action,
  input  bfa_pkg::bfa_sts_t  sts,
  input  logic               out_free,
  output logic               in_ready,
  output logic               emit,
  output bfa_pkg::bfa_cmd_t  cmd
);
  import bfa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    emit      = 1'b0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_action == ACT_ALLOC) ? S_SCAN : S_RESULT;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          cmd.take  = 1'b1;
          state_nxt = S_RESULT;
        end else if (sts.exhausted) begin
          cmd.fail  = 1'b1;
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/bfa_datapath.sv
// ---------------------------------------------------------------------------
// bfa_datapath
// Bitmap memory, scan pointers, first-free search, free count and limit.
// ---------------------------------------------------------------------------
module bfa_datapath #(
  parameter int MAX_ENTRIES = 8192,
  parameter int WORD_BITS   = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bfa_pkg::bfa_cmd_t           cmd,
  input  logic                        cfg_we,
  input  logic [bfa_pkg::NUM_W-1:0]   cfg_wdata,
  input  bfa_pkg::action_t            in_action,
  input  logic [bfa_pkg::WIDX_W-1:0]  in_word_index,
  input  logic [bfa_pkg::WDATA_W-1:0] in_word_data,
  input  logic [bfa_pkg::NUM_W-1:0]   in_count_value,
  output bfa_pkg::bfa_sts_t           sts,
  output logic [bfa_pkg::NUM_W-1:0]   res_number,
  output logic                        res_none,
  output logic [bfa_pkg::NUM_W-1:0]   res_free
);
  import bfa_pkg::*;

  localparam int WORD_COUNT = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int PTR_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BASE_W     = $clog2(MAX_ENTRIES + WORD_BITS + 1);
  localparam int BIT_W      = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] mem [WORD_COUNT];

  logic [NUM_W-1:0]     limit_cfg_r;
  logic [NUM_W-1:0]     free_r;
  logic                 chk_v_r;
  logic [NUM_W-1:0]     res_number_r;
  logic                 res_none_r;
  logic [BASE_W-1:0]    limit_r;
  logic [PTR_W-1:0]     issue_ptr_r;
  logic [BASE_W-1:0]    issue_base_r;
  logic [PTR_W-1:0]     chk_ptr_r;
  logic [BASE_W-1:0]    chk_base_r;
  logic [WORD_BITS-1:0] rd_data_r;

  logic                 issue;
  logic                 load_we;
  logic [BASE_W-1:0]    eff_limit;
  logic [BASE_W-1:0]    rem;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] avail;
  logic [WORD_BITS-1:0] hit_onehot;
  logic [BIT_W-1:0]     hit_idx;
  logic [31:0]          num_sum;

  // Search limit clamped to the bitmap capacity
  assign eff_limit = (32'(limit_cfg_r) > 32'(MAX_ENTRIES)) ? BASE_W'(MAX_ENTRIES)
                                                            : BASE_W'(limit_cfg_r);

  assign load_we = cmd.accept && (in_action == ACT_LOAD_WORD) &&
                   (32'(in_word_index) < 32'(WORD_COUNT));

  // Read the next word while the scan still lies below the limit
  assign issue = cmd.scan && !sts.hit && (issue_base_r < limit_r);

  // Check stage: free entries of the fetched word that lie below the limit
  assign rem = limit_r - chk_base_r;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = (BASE_W'(b) < rem);
    end
  end

  assign avail      = ~rd_data_r & mask;
  assign hit_onehot = avail & (~avail + 1'b1);

  always_comb begin
    hit_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        hit_idx = BIT_W'(b);
      end
    end
  end

  assign num_sum = 32'(chk_base_r) + 32'(hit_idx) + 32'd1;

  assign sts.hit       = chk_v_r && (|avail);
  assign sts.exhausted = !chk_v_r && (issue_base_r >= limit_r);

  // Bitmap memory: one write port (load or claim), one registered read
  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[PTR_W'(in_word_index)] <= WORD_BITS'(in_word_data);
    end else if (cmd.take) begin
      mem[chk_ptr_r] <= rd_data_r | hit_onehot;
    end
    if (issue) begin
      rd_data_r <= mem[issue_ptr_r];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_cfg_r <= LIMIT_RESET;
      free_r      <= '0;
      chk_v_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_cfg_r <= cfg_wdata;
      end
      if (cmd.accept && (in_action == ACT_LOAD_COUNT)) begin
        free_r <= in_count_value;
      end else if (cmd.take && (free_r != '0)) begin
        free_r <= free_r - 1'b1;
      end
      chk_v_r <= issue;
    end
  end

  // Scan pointers and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      issue_ptr_r  <= '0;
      issue_base_r <= '0;
      limit_r      <= eff_limit;
      res_number_r <= '0;
      res_none_r   <= 1'b0;
    end else begin
      if (issue) begin
        issue_ptr_r  <= issue_ptr_r + 1'b1;
        issue_base_r <= issue_base_r + BASE_W'(WORD_BITS);
        chk_ptr_r    <= issue_ptr_r;
        chk_base_r   <= issue_base_r;
      end
      if (cmd.take) begin
        res_number_r <= num_sum[NUM_W-1:0];
      end
      if (cmd.fail) begin
        res_none_r <= 1'b1;
      end
    end
  end

  assign res_number = res_number_r;
  assign res_none   = res_none_r;
  assign res_free   = free_r;

endmodule

// File: rtl/bitmap_first_free_allocator_unit.sv
// ---------------------------------------------------------------------------
// bitmap_first_free_allocator_unit
// First-fit allocator over a usage bitmap with a saturating free count.
// ---------------------------------------------------------------------------
// One request at a time. A load word or load count request (or an unused
// action code) goes through the result state into the output register,
// which raises out_tvalid. An allocate request reads the bitmap memory one
// word per cycle through its single registered read port and claims the
// lowest clear bit below the limit. Its result too waits in the result
// state while the output register is full and out_tready is low. A new
// request is taken while the last result still waits on the output
// register. The bitmap has no reset: every word below the limit must be
// loaded before the first allocate.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bitmap_first_free_allocator_unit #(
  parameter int MAX_ENTRIES = 8192,
  parameter int WORD_BITS   = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // entry_limit register
  input  logic                        cfg_we,
  input  logic [bfa_pkg::NUM_W-1:0]   cfg_wdata,
  // requests
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [1:0] action, [9:2] word_index, [41:10] word_data, [55:42] count_value
  input  logic [bfa_pkg::IN_W-1:0]    in_tdata,
  // results
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [13:0] allocated_number, [14] none_free, [28:15] free_left, [31:29] zero
  output logic [bfa_pkg::OUT_W-1:0]   out_tdata
);
  import bfa_pkg::*;

  action_t            in_action;
  logic [WIDX_W-1:0]  in_word_index;
  logic [WDATA_W-1:0] in_word_data;
  logic [NUM_W-1:0]   in_count_value;

  bfa_cmd_t           cmd;
  bfa_sts_t           sts;
  logic               emit;
  logic               out_free;
  logic [NUM_W-1:0]   res_number;
  logic               res_none;
  logic [NUM_W-1:0]   res_free;

  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;

  // Request fields
  assign in_action      = in_tdata[1:0];
  assign in_word_index  = in_tdata[9:2];
  assign in_word_data   = in_tdata[41:10];
  assign in_count_value = in_tdata[55:42];

  // Output register is free once empty or drained this cycle
  assign out_free = !out_valid_r || out_tready;

  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_action(in_action),
    .sts      (sts),
    .out_free (out_free),
    .in_ready (in_tready),
    .emit     (emit),
    .cmd      (cmd)
  );

  bfa_datapath #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .WORD_BITS  (WORD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_action     (in_action),
    .in_word_index (in_word_index),
    .in_word_data  (in_word_data),
    .in_count_value(in_count_value),
    .sts           (sts),
    .res_number    (res_number),
    .res_none      (res_none),
    .res_free      (res_free)
  );

  // Result holding register between the sequencer and the consumer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {{OUT_PAD{1'b0}}, res_free, res_none, res_number};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A full report never carries an entry number
  `BFA_ASSERT(a_none_zero, (out_tvalid && out_tdata[14]) |-> (out_tdata[13:0] == 14'd0), "none_free with nonzero number")
  // A failed scan leaves a clean full result
  `BFA_ASSERT(a_fail_result, cmd.fail |=> (res_none && (res_number == '0)), "fail result wrong")
  // Free count only rises through a load count request
  `BFA_ASSERT(a_free_mono, !(cmd.accept && (in_action == ACT_LOAD_COUNT)) |=> (res_free <= $past(res_free)), "free count rose")
  // Claim and failure are exclusive
  `BFA_NEVER(a_take_fail, cmd.take && cmd.fail, "take and fail together")

endmodule

// File: dv/bitmap_first_free_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bitmap_first_free_allocator_unit_tb
// Self-checking bench for the first-fit bitmap allocator. A scripted run
// covers the limit corners, the saturating count, unused action codes and a
// full bitmap. Three random phases follow, each with a different entry limit
// and backpressure mix. Results are checked in order against a
// cycle-free model of the bitmap and free count.
// ---------------------------------------------------------------------------
module bitmap_first_free_allocator_unit_tb;
  import bfa_pkg::*;

  localparam int CAPACITY         = 8192;
  localparam int WORD_W           = 32;
  localparam int WORD_CNT         = CAPACITY / WORD_W;
  localparam int QUIET_LIMIT      = 4000;  // above a full scan plus stalls
  localparam int TAIL_CYCLES      = 300;
  localparam int RANDOM_PER_PHASE = 340;

  // Spare action code; the block must leave its state alone.
  localparam action_t ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic             none;
    logic [NUM_W-1:0] free;
  } alloc_result_t;

  typedef enum logic [1:0] {ROW_REQ, ROW_CFG, ROW_FILL} row_kind_t;

  // One scripted step. value is the count for a request, or the limit for
  // a register write. A fill loads every word with data.
  typedef struct packed {
    row_kind_t        kind;
    action_t          act;
    logic [7:0]       idx;
    logic [31:0]      data;
    logic [NUM_W-1:0] value;
    logic             typed;
    alloc_result_t    res;
  } stim_row_t;

  localparam int SCRIPT_LEN = 26;

  stim_row_t script [SCRIPT_LEN] = '{
    // free count comes out of reset at zero
    '{ROW_REQ, ACT_LOAD_WORD, 8'd0, 32'h0000_0000, 14'd0, 1'b1, '{14'd0, 1'b0, 14'd0}},
    '{ROW_REQ, ACT_LOAD_WORD, 8'd1, 32'h0000_00FF, 14'd0, 1'b1, '{14'd0, 1'b0, 14'd0}},
    // limit of zero: nothing may be searched
    '{ROW_CFG, ACT_LOAD_WORD, 8'd0, 32'h0, 14'd0, 1'b0, '0},
    '{ROW_REQ, ACT_ALLOC, 8'd0, 32'h0, 14'd0, 1'b1, '{14'd0, 1'b1, 14'd0}},
    // single entry; count already zero stays zero on success
    '{ROW_CFG, ACT_LOAD_WORD, 8'd0, 32'h0, 14'd1, 1'b0, '0},
    '{ROW_REQ, ACT_ALLOC, 8'd0, 32'h0, 14'd0, 1'b1, '{14'd1, 1'b0, 14'd0}},
    '{ROW_REQ, ACT_ALLOC, 8'd0, 32'h0, 14'd0, 1'b1, '{14'd0, 1'b1, 14'd0}},
    // count field at its all-ones value
    '{ROW_REQ, ACT_LOAD_COUNT, 8'd0, 32'h0, 14'd16383, 1'b1, '{14'd0, 1'b0, 14'd16383}},
    // unused code with every other field high
    '{ROW_REQ, ACT_UNUSED, 8'd255, 32'hFFFF_FFFF, 14'd16383, 1'b1,
      '{14'd0, 1'b0, 14'd16383}},
    '{ROW_REQ, ACT_LOAD_WORD, 8'd0, 32'hFFFF_FFFF, 14'd0, 1'b1, '{14'd0, 1'b0, 14'd16383}},
    // limit ends inside word 1: its clear upper bits are out of reach
    '{ROW_CFG, ACT_LOAD_WORD, 8'd0, 32'h0, 14'd40, 1'b0, '0},
    '{ROW_REQ, ACT_ALLOC, 8'd0, 32'h0, 14'd0, 1'b1, '{14'd0, 1'b1, 14'd16383}},
    '{ROW_CFG, ACT_LOAD_WORD, 8'd0, 32'h0, 14'd41, 1'b0, '0},
    '{ROW_REQ, ACT_ALLOC, 8'd0, 32'h0, 14'd0, 1'b0, '0},
    '{ROW_REQ, ACT_LOAD_COUNT, 8'd0, 32'h0, 14'd0, 1'b1, '{14'd0, 1'b0, 14'd0}},
    // whole bitmap in use
    '{ROW_FILL, ACT_LOAD_WORD, 8'd0, 32'hFFFF_FFFF, 14'd0, 1'b0, '0},
    '{ROW_CFG, ACT_LOAD_WORD, 8'd0, 32'h0, 14'd8192, 1'b0, '0},
    '{ROW_REQ, ACT_ALLOC, 8'd0, 32'h0, 14'd0, 1'b1, '{14'd0, 1'b1, 14'd0}},
    // only the very last entry free
    '{ROW_REQ, ACT_LOAD_WORD, 8'd255, 32'h7FFF_FFFF, 14'd0, 1'b1, '{14'd0, 1'b0, 14'd0}},
    '{ROW_REQ, ACT_LOAD_COUNT, 8'd0, 32'h0, 14'd8192, 1'b1, '{14'd0, 1'b0, 14'd8192}},
    '{ROW_REQ, ACT_ALLOC, 8'd0, 32'h0, 14'd0, 1'b1, '{14'd8192, 1'b0, 14'd8191}},
    // limit above capacity is clipped to the bitmap size
    '{ROW_CFG, ACT_LOAD_WORD, 8'd0, 32'h0, 14'd16383, 1'b0, '0},
    '{ROW_REQ, ACT_LOAD_WORD, 8'd128, 32'hFFFE_FFFF, 14'd0, 1'b0, '0},
    '{ROW_REQ, ACT_ALLOC, 8'd0, 32'h0, 14'd0, 1'b0, '0},
    '{ROW_REQ, ACT_ALLOC, 8'd0, 32'h0, 14'd0, 1'b1, '{14'd0, 1'b1, 14'd8190}},
    '{ROW_REQ, ACT_LOAD_WORD, 8'd170, 32'hAAAA_5555, 14'd0, 1'b0, '0}
  };

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [NUM_W-1:0]  cfg_wdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;   // [1:0] action, [9:2] word_index, [41:10] word_data,
                                 // [55:42] count_value
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;  // [13:0] allocated_number, [14] none_free,
                                 // [28:15] free_left

  // Model state: bitmap, free count and the search limit.
  logic [WORD_W-1:0] usage_map [WORD_CNT];
  logic [NUM_W-1:0]  free_entries;
  logic [NUM_W-1:0]  limit_reg;

  alloc_result_t awaited_results[$];
  int            errors = 0;
  int            in_idle_pct;
  int            out_idle_pct;
  int            quiet_cycles = 0;

  bitmap_first_free_allocator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one request to the model and returns the result it must give.
  function automatic alloc_result_t predict_alloc(input action_t act, input logic [7:0] idx,
                                                  input logic [31:0] data,
                                                  input logic [NUM_W-1:0] cval);
    alloc_result_t r;
    int            span;
    int            e;
    r = '0;
    case (act)
      ACT_LOAD_WORD:  usage_map[idx] = data;
      ACT_LOAD_COUNT: free_entries = cval;
      ACT_ALLOC: begin
        span = (limit_reg > CAPACITY) ? CAPACITY : int'(limit_reg);
        r.none = 1'b1;
        for (e = 0; e < span; e++) begin
          if (!usage_map[e / WORD_W][e % WORD_W]) begin
            usage_map[e / WORD_W][e % WORD_W] = 1'b1;
            r.number = NUM_W'(e + 1);
            r.none   = 1'b0;
            break;
          end
        end
        // count saturates at zero
        if (!r.none && free_entries != 0) free_entries = free_entries - 1'b1;
      end
      default: ;
    endcase
    r.free = free_entries;
    return r;
  endfunction

  // Entered and left on a falling edge. The expectation is queued only once
  // the request is taken, so model state follows the block's order.
  task automatic push_request(input action_t act, input logic [7:0] idx,
                              input logic [31:0] data, input logic [NUM_W-1:0] cval,
                              input logic typed, input alloc_result_t typed_res);
    alloc_result_t predicted;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {cval, data, idx, act};
    do @(posedge clk); while (!in_tready);
    predicted = predict_alloc(act, idx, data, cval);
    awaited_results.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  // Stop sending, let every outstanding result drain, then hold a while.
  task automatic settle(input int cycles);
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (cycles) @(negedge clk);
  endtask

  // Limit is only changed with the block idle.
  task automatic write_limit(input logic [NUM_W-1:0] value);
    settle(4);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    limit_reg = value;
  endtask

  // Receiver backpressure, redrawn every cycle.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // Result checker: in-order compare against the oldest expectation.
  always @(posedge clk) begin
    alloc_result_t want;
    alloc_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.number = out_tdata[NUM_W-1:0];
      got.none   = out_tdata[NUM_W];
      got.free   = out_tdata[2*NUM_W:NUM_W+1];
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: result number=%0d none=%0d free=%0d with no request outstanding",
                 $time, got.number, got.none, got.free);
      end else begin
        want = awaited_results.pop_front();
        if (got.number !== want.number || got.none !== want.none ||
            got.free !== want.free) begin
          errors++;
          $display("%0t: expected number=%0d none=%0d free=%0d, got number=%0d none=%0d free=%0d",
                   $time, want.number, want.none, want.free,
                   got.number, got.none, got.free);
        end
      end
    end
  end

  // Watchdog: any stretch with no request or result moving is a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: nothing moved for %0d cycles", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int               phase;
    int               n;
    int               pick;
    action_t          act;
    logic [7:0]       idx;
    logic [31:0]      data;
    logic [NUM_W-1:0] cval;
    logic [NUM_W-1:0] phase_limit;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    free_entries = '0;
    limit_reg    = LIMIT_RESET;
    in_idle_pct  = 21;
    out_idle_pct = 50;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Scripted corners
    foreach (script[i]) begin
      case (script[i].kind)
        ROW_CFG:  write_limit(script[i].value);
        ROW_FILL: begin
          for (n = 0; n < WORD_CNT; n++)
            push_request(ACT_LOAD_WORD, n[7:0], script[i].data, '0, 1'b0, '0);
        end
        default:  push_request(script[i].act, script[i].idx, script[i].data,
                               script[i].value, script[i].typed, script[i].res);
      endcase
    end

    // Random phases. The whole bitmap was loaded by the script, so any
    // limit is safe. Loads lean toward full words so scans run deep.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          in_idle_pct  = 21;
          out_idle_pct = 50;
          phase_limit  = LIMIT_RESET;
        end
        1: begin
          in_idle_pct  = 50;
          out_idle_pct = 21;
          phase_limit  = NUM_W'($urandom_range(33, 8191));
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
          phase_limit  = 14'd16383;
        end
      endcase
      write_limit(phase_limit);

      repeat (RANDOM_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)      act = ACT_ALLOC;
        else if (pick < 85) act = ACT_LOAD_WORD;
        else if (pick < 95) act = ACT_LOAD_COUNT;
        else                act = ACT_UNUSED;
        idx  = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 9);
        if (pick < 6)      data = 32'hFFFF_FFFF;
        else if (pick < 8) data = ~(32'd1 << $urandom_range(0, 31));
        else               data = $urandom;
        if ($urandom_range(0, 3) == 0) cval = NUM_W'($urandom_range(0, 16383));
        else                           cval = NUM_W'($urandom_range(0, 8192));
        push_request(act, idx, data, cval, 1'b0, '0);
      end
    end

    // Drain, then give a stray late result time to show up.
    settle(TAIL_CYCLES);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/bfa_pkg.sv
rtl/bfa_ctrl.sv
rtl/bfa_datapath.sv
rtl/bitmap_first_free_allocator_unit.sv
dv/bitmap_first_free_allocator_unit_tb.sv
